/* sv/ucp_pkg.sv */
// Shared types, constants, text tables and microcode for the command parser.
package ucp_pkg;

  localparam int BUFFER_DEPTH = 16;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
  localparam int CNT_W        = (FILL_W > 6) ? FILL_W : 6;
  localparam int UPC_W        = 5;
  localparam int DUTY_W       = 7;
  localparam int ACC_W        = 10;
  localparam int TXT_W        = 8 * 38;

  // Command words
  localparam int CMD_ON_LEN     = 2;
  localparam int CMD_OFF_LEN    = 3;
  localparam int CMD_STATUS_LEN = 6;
  localparam int CMD_PWM_LEN    = 4;
  localparam logic [8*CMD_ON_LEN-1:0]     CMD_ON     = "ON";
  localparam logic [8*CMD_OFF_LEN-1:0]    CMD_OFF    = "OFF";
  localparam logic [8*CMD_STATUS_LEN-1:0] CMD_STATUS = "Status";
  localparam logic [8*CMD_PWM_LEN-1:0]    CMD_PWM    = "PWM:";
  localparam logic [7:0] CHAR_PCT  = 8'h25;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam int PWM_MIN_LEN = 6;
  localparam int PWM_MAX_LEN = 8;
  localparam int DUTY_MAX    = 100;

  // Reply texts
  localparam int TXT_RX_LEN      = 31;
  localparam int TXT_PWM_LEN     = 31;
  localparam int TXT_USE_LEN     = 38;
  localparam int TXT_LED_ON_LEN  = 12;
  localparam int TXT_LED_OFF_LEN = 13;
  localparam int TXT_OUT_LEN     = 10;
  localparam int TXT_END_LEN     = 3;
  localparam logic [8*TXT_RX_LEN-1:0] TXT_RX_STR =
    {"ERROR: RX or command too long", 8'h0D, 8'h0A};
  localparam logic [8*TXT_PWM_LEN-1:0] TXT_PWM_STR =
    {"ERROR: use PWM:0%!..PWM:100%!", 8'h0D, 8'h0A};
  localparam logic [8*TXT_USE_LEN-1:0] TXT_USE_STR =
    {"ERROR: use ON! OFF! PWM:50%! Status!", 8'h0D, 8'h0A};
  localparam logic [8*TXT_LED_ON_LEN-1:0]  TXT_LED_ON_STR  = "LED=ON; PWM=";
  localparam logic [8*TXT_LED_OFF_LEN-1:0] TXT_LED_OFF_STR = "LED=OFF; PWM=";
  localparam logic [8*TXT_OUT_LEN-1:0]     TXT_OUT_STR     = "%; OUTPUT=";
  localparam logic [8*TXT_END_LEN-1:0]     TXT_END_STR     = {"%", 8'h0D, 8'h0A};

  typedef enum logic [2:0] {
    TXT_RX, TXT_PWM, TXT_USE, TXT_LED_ON, TXT_LED_OFF, TXT_OUT, TXT_END
  } txt_t;

  typedef enum logic [2:0] {
    UOP_SCAN, UOP_JUMP, UOP_TEXT, UOP_NUM, UOP_SETLED, UOP_CLRLED, UOP_SETDUTY, UOP_DONE
  } uop_t;

  typedef enum logic [2:0] {
    COND_ALWAYS, COND_OVF, COND_ON, COND_OFF, COND_STATUS, COND_PFX, COND_PWM, COND_LED
  } cond_t;

  typedef enum logic {NUM_DUTY, NUM_DRIVE} num_sel_t;

  typedef struct packed {
    uop_t             op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    txt_t             txt;
    num_sel_t         num;
    logic             last_beat;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic   busy;
    uword_t uw;
  } ucp_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic step_done;
    logic ovf;
    logic hit_on;
    logic hit_off;
    logic hit_status;
    logic hit_pfx;
    logic hit_pwm;
    logic led;
  } ucp_stat_t;

  // Program labels
  localparam logic [UPC_W-1:0] L_ON      = UPC_W'(8);
  localparam logic [UPC_W-1:0] L_OFF     = UPC_W'(10);
  localparam logic [UPC_W-1:0] L_PFX     = UPC_W'(12);
  localparam logic [UPC_W-1:0] L_SETDUTY = UPC_W'(15);
  localparam logic [UPC_W-1:0] L_STAT    = UPC_W'(16);
  localparam logic [UPC_W-1:0] L_LEDON   = UPC_W'(19);
  localparam logic [UPC_W-1:0] L_DUTY    = UPC_W'(20);
  localparam logic [UPC_W-1:0] L_RX      = UPC_W'(25);

  function automatic uword_t u_op(uop_t op);
    return '{op, COND_ALWAYS, '0, TXT_RX, NUM_DUTY, 1'b0};
  endfunction

  function automatic uword_t u_jmp(cond_t cond, logic [UPC_W-1:0] target);
    return '{UOP_JUMP, cond, target, TXT_RX, NUM_DUTY, 1'b0};
  endfunction

  function automatic uword_t u_txt(txt_t txt, logic last_beat);
    return '{UOP_TEXT, COND_ALWAYS, '0, txt, NUM_DUTY, last_beat};
  endfunction

  function automatic uword_t u_num(num_sel_t num);
    return '{UOP_NUM, COND_ALWAYS, '0, TXT_RX, num, 1'b0};
  endfunction

  // Control store
  function automatic uword_t ucode(logic [UPC_W-1:0] upc);
    uword_t w;
    case (upc)
      5'd0:  w = u_op(UOP_SCAN);
      5'd1:  w = u_jmp(COND_OVF, L_RX);
      5'd2:  w = u_jmp(COND_ON, L_ON);
      5'd3:  w = u_jmp(COND_OFF, L_OFF);
      5'd4:  w = u_jmp(COND_STATUS, L_STAT);
      5'd5:  w = u_jmp(COND_PFX, L_PFX);
      5'd6:  w = u_txt(TXT_USE, 1'b1);
      5'd7:  w = u_op(UOP_DONE);
      5'd8:  w = u_op(UOP_SETLED);
      5'd9:  w = u_jmp(COND_ALWAYS, L_STAT);
      5'd10: w = u_op(UOP_CLRLED);
      5'd11: w = u_jmp(COND_ALWAYS, L_STAT);
      5'd12: w = u_jmp(COND_PWM, L_SETDUTY);
      5'd13: w = u_txt(TXT_PWM, 1'b1);
      5'd14: w = u_op(UOP_DONE);
      5'd15: w = u_op(UOP_SETDUTY);
      5'd16: w = u_jmp(COND_LED, L_LEDON);
      5'd17: w = u_txt(TXT_LED_OFF, 1'b0);
      5'd18: w = u_jmp(COND_ALWAYS, L_DUTY);
      5'd19: w = u_txt(TXT_LED_ON, 1'b0);
      5'd20: w = u_num(NUM_DUTY);
      5'd21: w = u_txt(TXT_OUT, 1'b0);
      5'd22: w = u_num(NUM_DRIVE);
      5'd23: w = u_txt(TXT_END, 1'b1);
      5'd24: w = u_op(UOP_DONE);
      5'd25: w = u_txt(TXT_RX, 1'b1);
      default: w = u_op(UOP_DONE);
    endcase
    return w;
  endfunction

  // Character at pos of a text held right-aligned, first character highest
  function automatic logic [7:0] str_pick(logic [TXT_W-1:0] s, int len, int pos);
    logic [7:0] ch;
    ch = '0;
    if (pos >= 0 && pos < len) begin
      ch = s[8*(len-1-pos) +: 8];
    end
    return ch;
  endfunction

  function automatic logic [5:0] txt_len(txt_t id);
    logic [5:0] n;
    case (id)
      TXT_RX:      n = 6'(TXT_RX_LEN);
      TXT_PWM:     n = 6'(TXT_PWM_LEN);
      TXT_USE:     n = 6'(TXT_USE_LEN);
      TXT_LED_ON:  n = 6'(TXT_LED_ON_LEN);
      TXT_LED_OFF: n = 6'(TXT_LED_OFF_LEN);
      TXT_OUT:     n = 6'(TXT_OUT_LEN);
      TXT_END:     n = 6'(TXT_END_LEN);
      default:     n = 6'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] txt_char(txt_t id, logic [5:0] pos);
    logic [7:0] ch;
    case (id)
      TXT_RX:      ch = str_pick(TXT_W'(TXT_RX_STR), TXT_RX_LEN, int'(pos));
      TXT_PWM:     ch = str_pick(TXT_W'(TXT_PWM_STR), TXT_PWM_LEN, int'(pos));
      TXT_USE:     ch = str_pick(TXT_W'(TXT_USE_STR), TXT_USE_LEN, int'(pos));
      TXT_LED_ON:  ch = str_pick(TXT_W'(TXT_LED_ON_STR), TXT_LED_ON_LEN, int'(pos));
      TXT_LED_OFF: ch = str_pick(TXT_W'(TXT_LED_OFF_STR), TXT_LED_OFF_LEN, int'(pos));
      TXT_OUT:     ch = str_pick(TXT_W'(TXT_OUT_STR), TXT_OUT_LEN, int'(pos));
      TXT_END:     ch = str_pick(TXT_W'(TXT_END_STR), TXT_END_LEN, int'(pos));
      default:     ch = '0;
    endcase
    return ch;
  endfunction

  // Decimal digit of v: pos 0 hundreds, 1 tens, 2 ones; divide by ten via *205 >> 11
  function automatic logic [7:0] dec_digit(logic [DUTY_W-1:0] v, logic [1:0] pos);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [3:0]  d;
    prod = 15'(v) * 15'd205;
    q    = prod[14:11];
    case (pos)
      2'd0:    d = (v >= DUTY_W'(100)) ? 4'd1 : 4'd0;
      2'd1:    d = (q >= 4'd10) ? 4'(q - 4'd10) : q;
      default: d = 4'(v - DUTY_W'(q) * DUTY_W'(10));
    endcase
    return CHAR_ZERO | {4'b0, d};
  endfunction

endpackage

/* sv/ucp_seq.sv */
// Microcode sequencer: step counter, control store and conditional jumps.
module ucp_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ucp_pkg::ucp_stat_t    stat,
  output ucp_pkg::ucp_ctrl_t    ctrl
);

  logic                           busy;
  logic                           busy_next;
  logic [ucp_pkg::UPC_W-1:0]      upc;
  logic [ucp_pkg::UPC_W-1:0]      upc_next;
  ucp_pkg::uword_t                uw;
  logic                           taken;

  // Fetch the control word
  assign uw        = ucp_pkg::ucode(upc);
  assign ctrl.busy = busy;
  assign ctrl.uw   = uw;

  // Evaluate the jump condition
  always_comb begin
    case (uw.cond)
      ucp_pkg::COND_ALWAYS: taken = 1'b1;
      ucp_pkg::COND_OVF:    taken = stat.ovf;
      ucp_pkg::COND_ON:     taken = stat.hit_on;
      ucp_pkg::COND_OFF:    taken = stat.hit_off;
      ucp_pkg::COND_STATUS: taken = stat.hit_status;
      ucp_pkg::COND_PFX:    taken = stat.hit_pfx;
      ucp_pkg::COND_PWM:    taken = stat.hit_pwm;
      ucp_pkg::COND_LED:    taken = stat.led;
      default:              taken = 1'b0;
    endcase
  end

  // Advance, jump or stop
  always_comb begin
    busy_next = busy;
    upc_next  = upc;
    if (start) begin
      busy_next = 1'b1;
      upc_next  = '0;
    end else if (busy) begin
      case (uw.op)
        ucp_pkg::UOP_JUMP: begin
          upc_next = taken ? uw.target : upc + ucp_pkg::UPC_W'(1);
        end
        ucp_pkg::UOP_DONE: begin
          busy_next = 1'b0;
        end
        default: begin
          if (stat.step_done) begin
            upc_next = upc + ucp_pkg::UPC_W'(1);
          end
        end
      endcase
    end
  end

  // Hold the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= '0;
    end else begin
      busy <= busy_next;
      upc  <= upc_next;
    end
  end

endmodule

/* sv/ucp_dp.sv */
// Datapath: command store, scan flags, LED settings and reply beat register.
module ucp_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_accept,
  input  logic [7:0]          in_char,
  input  logic                in_last,
  input  logic                in_err,
  input  ucp_pkg::ucp_ctrl_t  ctrl,
  output ucp_pkg::ucp_stat_t  stat,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,
  output logic                m_tlast
);

  logic [7:0]                       store [ucp_pkg::BUFFER_DEPTH];
  logic [ucp_pkg::FILL_W-1:0]       fill;
  logic                             overflow;
  logic                             led;
  logic [ucp_pkg::DUTY_W-1:0]       duty;
  logic [ucp_pkg::DUTY_W-1:0]       drive;
  logic [ucp_pkg::CNT_W-1:0]        cnt;
  logic                             rd_valid;
  logic [ucp_pkg::FILL_W-1:0]       rd_pos;
  logic [7:0]                       rd_data;
  logic                             on_ok;
  logic                             off_ok;
  logic                             st_ok;
  logic                             pfx_ok;
  logic                             pwm_ok;
  logic [ucp_pkg::ACC_W-1:0]        acc;
  logic [7:0]                       out_char;
  logic                             out_last;
  logic                             out_led;
  logic [ucp_pkg::DUTY_W-1:0]       out_duty;
  logic [ucp_pkg::DUTY_W-1:0]       out_drive;

  ucp_pkg::uword_t                  uw;
  logic                             run;
  logic                             slot_free;
  logic                             scan_reach;
  logic                             scan_issue;
  logic                             txt_end;
  logic [ucp_pkg::DUTY_W-1:0]       num_v;
  logic                             num_need;
  logic                             emit;
  logic [7:0]                       emit_char;
  logic                             emit_last;
  logic                             step_done;
  logic                             cnt_inc;
  logic                             store_wr;
  logic                             is_digit;
  logic                             pwm_len_ok;

  assign uw         = ctrl.uw;
  assign run        = ctrl.busy;
  assign drive      = led ? duty : '0;
  assign slot_free  = !m_tvalid || m_tready;
  assign scan_reach = (cnt[ucp_pkg::FILL_W-1:0] == fill);
  assign scan_issue = run && (uw.op == ucp_pkg::UOP_SCAN) && !scan_reach;
  assign txt_end    = (cnt == ucp_pkg::CNT_W'(ucp_pkg::txt_len(uw.txt)) - ucp_pkg::CNT_W'(1));
  assign num_v      = (uw.num == ucp_pkg::NUM_DRIVE) ? drive : duty;
  assign store_wr   = in_accept && !in_last && !in_err &&
                      (fill < ucp_pkg::FILL_W'(ucp_pkg::BUFFER_DEPTH));
  assign is_digit   = (rd_data >= ucp_pkg::CHAR_ZERO) && (rd_data <= ucp_pkg::CHAR_NINE);
  assign pwm_len_ok = (fill >= ucp_pkg::FILL_W'(ucp_pkg::PWM_MIN_LEN)) &&
                      (fill <= ucp_pkg::FILL_W'(ucp_pkg::PWM_MAX_LEN));

  // Skip leading zero digits
  always_comb begin
    case (cnt[1:0])
      2'd0:    num_need = (num_v >= ucp_pkg::DUTY_W'(100));
      2'd1:    num_need = (num_v >= ucp_pkg::DUTY_W'(10));
      default: num_need = 1'b1;
    endcase
  end

  // Execute the current control word
  always_comb begin
    emit      = 1'b0;
    emit_char = '0;
    emit_last = 1'b0;
    step_done = 1'b0;
    cnt_inc   = 1'b0;
    if (run) begin
      case (uw.op)
        ucp_pkg::UOP_SCAN: begin
          step_done = scan_reach && !rd_valid;
          cnt_inc   = scan_issue;
        end
        ucp_pkg::UOP_TEXT: begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_char = ucp_pkg::txt_char(uw.txt, cnt[5:0]);
            emit_last = uw.last_beat && txt_end;
            step_done = txt_end;
            cnt_inc   = 1'b1;
          end
        end
        ucp_pkg::UOP_NUM: begin
          if (!num_need) begin
            cnt_inc = 1'b1;
          end else if (slot_free) begin
            emit      = 1'b1;
            emit_char = ucp_pkg::dec_digit(num_v, cnt[1:0]);
            step_done = (cnt[1:0] == 2'd2);
            cnt_inc   = 1'b1;
          end
        end
        ucp_pkg::UOP_SETLED, ucp_pkg::UOP_CLRLED, ucp_pkg::UOP_SETDUTY: begin
          step_done = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Report flags to the sequencer
  always_comb begin
    stat.step_done  = step_done;
    stat.ovf        = overflow;
    stat.hit_on     = on_ok && (fill == ucp_pkg::FILL_W'(ucp_pkg::CMD_ON_LEN));
    stat.hit_off    = off_ok && (fill == ucp_pkg::FILL_W'(ucp_pkg::CMD_OFF_LEN));
    stat.hit_status = st_ok && (fill == ucp_pkg::FILL_W'(ucp_pkg::CMD_STATUS_LEN));
    stat.hit_pfx    = pfx_ok && (fill >= ucp_pkg::FILL_W'(ucp_pkg::CMD_PWM_LEN));
    stat.hit_pwm    = pfx_ok && pwm_len_ok && pwm_ok &&
                      (acc <= ucp_pkg::ACC_W'(ucp_pkg::DUTY_MAX));
    stat.led        = led;
  end

  // Command store: write while filling, registered read while scanning
  always_ff @(posedge clk) begin
    if (store_wr) begin
      store[fill[ucp_pkg::ADDR_W-1:0]] <= in_char;
    end
    if (scan_issue) begin
      rd_data <= store[cnt[ucp_pkg::ADDR_W-1:0]];
      rd_pos  <= cnt[ucp_pkg::FILL_W-1:0];
    end
  end

  // Control state, settings and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      overflow <= 1'b0;
      led      <= 1'b0;
      duty     <= '0;
      cnt      <= '0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_accept) begin
        if (in_err) begin
          overflow <= 1'b1;
        end else if (!in_last) begin
          if (store_wr) begin
            fill <= fill + ucp_pkg::FILL_W'(1);
          end else begin
            overflow <= 1'b1;
          end
        end
      end
      if (run) begin
        case (uw.op)
          ucp_pkg::UOP_DONE: begin
            fill     <= '0;
            overflow <= 1'b0;
          end
          ucp_pkg::UOP_SETLED:  led  <= 1'b1;
          ucp_pkg::UOP_CLRLED:  led  <= 1'b0;
          ucp_pkg::UOP_SETDUTY: duty <= acc[ucp_pkg::DUTY_W-1:0];
          default: begin
          end
        endcase
      end
      if (step_done) begin
        cnt <= '0;
      end else if (cnt_inc) begin
        cnt <= cnt + ucp_pkg::CNT_W'(1);
      end
      rd_valid <= scan_issue;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Match flags and digit accumulator, one stored character a cycle
  always_ff @(posedge clk) begin
    if (in_accept && in_last) begin
      on_ok  <= 1'b1;
      off_ok <= 1'b1;
      st_ok  <= 1'b1;
      pfx_ok <= 1'b1;
      pwm_ok <= 1'b1;
      acc    <= '0;
    end else if (rd_valid) begin
      on_ok  <= on_ok && (rd_pos < ucp_pkg::FILL_W'(ucp_pkg::CMD_ON_LEN)) &&
                (rd_data == ucp_pkg::str_pick(ucp_pkg::TXT_W'(ucp_pkg::CMD_ON),
                                              ucp_pkg::CMD_ON_LEN, int'(rd_pos)));
      off_ok <= off_ok && (rd_pos < ucp_pkg::FILL_W'(ucp_pkg::CMD_OFF_LEN)) &&
                (rd_data == ucp_pkg::str_pick(ucp_pkg::TXT_W'(ucp_pkg::CMD_OFF),
                                              ucp_pkg::CMD_OFF_LEN, int'(rd_pos)));
      st_ok  <= st_ok && (rd_pos < ucp_pkg::FILL_W'(ucp_pkg::CMD_STATUS_LEN)) &&
                (rd_data == ucp_pkg::str_pick(ucp_pkg::TXT_W'(ucp_pkg::CMD_STATUS),
                                              ucp_pkg::CMD_STATUS_LEN, int'(rd_pos)));
      if (rd_pos < ucp_pkg::FILL_W'(ucp_pkg::CMD_PWM_LEN)) begin
        pfx_ok <= pfx_ok &&
                  (rd_data == ucp_pkg::str_pick(ucp_pkg::TXT_W'(ucp_pkg::CMD_PWM),
                                                ucp_pkg::CMD_PWM_LEN, int'(rd_pos)));
      end else if (rd_pos == fill - ucp_pkg::FILL_W'(1)) begin
        pwm_ok <= pwm_ok && (rd_data == ucp_pkg::CHAR_PCT);
      end else begin
        pwm_ok <= pwm_ok && is_digit;
        acc    <= ucp_pkg::ACC_W'({acc, 3'b000} + {2'b00, acc, 1'b0} + {9'b0, rd_data[3:0]});
      end
    end
  end

  // Reply beat register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_char  <= emit_char;
      out_last  <= emit_last;
      out_led   <= led;
      out_duty  <= duty;
      out_drive <= drive;
    end
  end

  assign m_tdata = {1'b0, out_drive, out_duty, out_led, out_char};
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= ucp_pkg::FILL_W'(ucp_pkg::BUFFER_DEPTH))
    else $error("fill count beyond store depth");

  a_reply_in_run: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(ctrl.busy))
    else $error("reply beat raised with no program running");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (ctrl.busy && ctrl.uw.op == ucp_pkg::UOP_DONE) |=> (fill == '0 && !overflow))
    else $error("command not cleared after reply program");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (rd_pos < fill))
    else $error("scan read beyond filled entries");
`endif

endmodule

/* sv/uart_led_pwm_command_parser.sv */
// Top level: UART command parser that sets LED enable and PWM duty and streams a reply.
//
//  channel | dir | tdata (low bit up)                                   | tlast         | tuser
//  s_*     | in  | [7:0] rx_char                                        | end_of_command| receive_error
//  m_*     | out | [7:0] reply_char, [8] led_enabled_out,               | reply_last    | -
//          |     | [15:9] duty_percent_out, [22:16] drive_percent, [23]=0|               |
//
//  A character beat goes into the command store if it has room and tuser is low.
//  A closing beat starts the microprogram: scan of the store (one memory read a cycle),
//  up to nine jump and setting steps, the reply beats plus up to two skipped digit slots
//  per number, and one finishing step.
//  s_tready stays low while the program runs; m_tready low stalls the sequencer.
//  Reset turns the LED off, sets duty to 0 and empties the store; no clearing pass.
module uart_led_pwm_command_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_char
  input  logic        s_tlast,
  input  logic        s_tuser,   // [0] receive_error
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] reply_char, [8] led_enabled_out,
                                 // [15:9] duty_percent_out, [22:16] drive_percent
  output logic        m_tlast
);

  ucp_pkg::ucp_ctrl_t ctrl;
  ucp_pkg::ucp_stat_t stat;
  logic               in_accept;
  logic               start;

  // Take input beats only while no reply program runs
  assign s_tready  = !ctrl.busy;
  assign in_accept = s_tvalid && s_tready;
  assign start     = in_accept && s_tlast;

  ucp_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  ucp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_char   (s_tdata),
    .in_last   (s_tlast),
    .in_err    (s_tuser),
    .ctrl      (ctrl),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

/* tb/tb_uart_led_pwm_command_parser.sv */
// Testbench for the UART LED/PWM command parser: random commands in, reply beats scored.
module tb_uart_led_pwm_command_parser;

  localparam int STALL_LIMIT  = 2000;
  localparam int ITEM_TARGET  = 220;
  localparam int DRAIN_CYCLES = 100;
  localparam int REPORT_MAX   = 10;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // One reply beat as seen on the master side
  typedef struct packed {
    logic [7:0]                 ch;
    logic                       last;
    logic                       led;
    logic [ucp_pkg::DUTY_W-1:0] duty;
    logic [ucp_pkg::DUTY_W-1:0] drive;
  } reply_beat_t;

  // One received beat as driven on the slave side
  typedef struct {
    logic [7:0] ch;
    bit         eoc;
    bit         err;
  } rx_beat_t;

  // Command interpreter mirror plus the queue of reply beats still owed
  class reply_scoreboard;
    reply_beat_t                expected_q[$];
    logic [7:0]                 text_q[$];
    logic [7:0]                 cmd_store[ucp_pkg::BUFFER_DEPTH];
    int                         fill;
    bit                         ovf;
    bit                         led;
    logic [ucp_pkg::DUTY_W-1:0] duty;
    int                         mismatches;

    function new();
      fill       = 0;
      ovf        = 0;
      led        = 0;
      duty       = '0;
      mismatches = 0;
    endfunction

    function void add_text(string s);
      for (int i = 0; i < s.len(); i++) begin
        text_q.push_back(s[i]);
      end
    endfunction

    function void add_eol();
      text_q.push_back(CHAR_CR);
      text_q.push_back(CHAR_LF);
    endfunction

    // Decimal without leading zeros
    function void add_number(int v);
      if (v >= 100) text_q.push_back(8'(48 + v / 100));
      if (v >= 10) text_q.push_back(8'(48 + (v / 10) % 10));
      text_q.push_back(8'(48 + v % 10));
    endfunction

    function void add_status();
      add_text(led ? "LED=ON; PWM=" : "LED=OFF; PWM=");
      add_number(int'(duty));
      add_text("%; OUTPUT=");
      add_number(led ? int'(duty) : 0);
      add_text("%");
      add_eol();
    endfunction

    function bit is_word(string w);
      if (w.len() != fill) return 0;
      for (int i = 0; i < fill; i++) begin
        if (cmd_store[i] != w[i]) return 0;
      end
      return 1;
    endfunction

    // Digits between the prefix and the trailing percent sign, at most 100
    function bit pwm_value(output int v);
      int         n;
      logic [7:0] c;
      n = fill;
      v = 0;
      if (n < 6 || n > 8) return 0;
      if (cmd_store[n-1] != "%") return 0;
      for (int k = 4; k < n - 1; k++) begin
        c = cmd_store[k];
        if (c < "0" || c > "9") return 0;
        v = v * 10 + int'(c - "0");
      end
      return (v <= ucp_pkg::DUTY_MAX);
    endfunction

    // Note an accepted input beat; a closing beat queues the whole reply
    function void note_beat(logic [7:0] ch, bit eoc, bit err);
      int          v;
      reply_beat_t rb;
      if (err) ovf = 1;
      if (!eoc) begin
        if (!err) begin
          if (fill < ucp_pkg::BUFFER_DEPTH) begin
            cmd_store[fill] = ch;
            fill++;
          end else begin
            ovf = 1;
          end
        end
        return;
      end
      text_q.delete();
      if (ovf) begin
        add_text("ERROR: RX or command too long");
        add_eol();
      end else if (is_word("ON")) begin
        led = 1;
        add_status();
      end else if (is_word("OFF")) begin
        led = 0;
        add_status();
      end else if (is_word("Status")) begin
        add_status();
      end else if (fill >= 4 && cmd_store[0] == "P" && cmd_store[1] == "W" &&
                   cmd_store[2] == "M" && cmd_store[3] == ":") begin
        if (pwm_value(v)) begin
          duty = ucp_pkg::DUTY_W'(v);
          add_status();
        end else begin
          add_text("ERROR: use PWM:0%!..PWM:100%!");
          add_eol();
        end
      end else begin
        add_text("ERROR: use ON! OFF! PWM:50%! Status!");
        add_eol();
      end
      foreach (text_q[i]) begin
        rb.ch    = text_q[i];
        rb.last  = (i == text_q.size() - 1);
        rb.led   = led;
        rb.duty  = duty;
        rb.drive = led ? duty : '0;
        expected_q.push_back(rb);
      end
      fill = 0;
      ovf  = 0;
    endfunction

    // Check an accepted reply beat against the oldest expectation
    function void check_beat(logic [23:0] data, logic last);
      reply_beat_t want;
      reply_beat_t got;
      got.ch    = data[7:0];
      got.last  = last;
      got.led   = data[8];
      got.duty  = data[15:9];
      got.drive = data[22:16];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected reply beat: char %h last %b led %b duty %0d drive %0d",
                   got.ch, got.last, got.led, got.duty, got.drive);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"reply mismatch: expected char %h last %b led %b duty %0d drive %0d,",
                    " got char %h last %b led %b duty %0d drive %0d"},
                   want.ch, want.last, want.led, want.duty, want.drive,
                   got.ch, got.last, got.led, got.duty, got.drive);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;  // [7:0] rx_char
  logic        s_tlast  = 1'b0;
  logic        s_tuser  = 1'b0;   // [0] receive_error
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [7:0] reply_char, [8] led_enabled_out,
                                  // [15:9] duty_percent_out, [22:16] drive_percent
  logic        m_tlast;

  reply_scoreboard sb = new();
  rx_beat_t        cmd_q[$];
  int              items;
  bit              no_idle;

  uart_led_pwm_command_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void put_beat(logic [7:0] ch, bit eoc, bit err);
    rx_beat_t b;
    b.ch  = ch;
    b.eoc = eoc;
    b.err = err;
    cmd_q.push_back(b);
  endfunction

  function automatic void put_chars(string s);
    for (int i = 0; i < s.len(); i++) begin
      put_beat(s[i], 1'b0, 1'b0);
    end
  endfunction

  function automatic void put_random(int n);
    for (int i = 0; i < n; i++) begin
      put_beat(8'($urandom_range(255)), 1'b0, 1'b0);
    end
  endfunction

  // Close the command; the character on this beat is don't-care
  function automatic void put_close(bit err);
    put_beat(8'($urandom_range(255)), 1'b1, err);
  endfunction

  function automatic void put_valid_pwm();
    int    r;
    int    v;
    string digits;
    r = $urandom_range(9);
    v = (r == 0) ? 0 : (r == 1) ? ucp_pkg::DUTY_MAX : $urandom_range(ucp_pkg::DUTY_MAX);
    case ($urandom_range(3))
      0:       digits = $sformatf("%03d", v);
      1:       digits = (v < 10) ? $sformatf("%02d", v) : $sformatf("%0d", v);
      default: digits = $sformatf("%0d", v);
    endcase
    put_chars({"PWM:", digits, "%"});
  endfunction

  function automatic void put_good_command();
    case ($urandom_range(3))
      0:       put_chars("ON");
      1:       put_chars("OFF");
      2:       put_chars("Status");
      default: put_valid_pwm();
    endcase
  endfunction

  // Build one random command, mostly well formed
  function automatic void build_command();
    int r;
    int pos;
    r = $urandom_range(99);
    if (r < 14) begin
      put_chars("ON");
    end else if (r < 24) begin
      put_chars("OFF");
    end else if (r < 33) begin
      put_chars("Status");
    end else if (r < 56) begin
      put_valid_pwm();
    end else if (r < 68) begin
      // broken duty commands
      case ($urandom_range(5))
        0: put_chars("PWM:");
        1: put_chars({"PWM:", $sformatf("%0d", $urandom_range(999, 101)), "%"});
        2: begin
          put_chars("PWM:");
          put_random(1);
          put_chars("%");
        end
        3: put_chars("PWM:50");
        4: put_chars("PWM:0005%");
        default: put_chars("PWM:%");
      endcase
    end else if (r < 74) begin
      put_random($urandom_range(8));
    end else if (r < 80) begin
      // near misses, a zero byte among them
      case ($urandom_range(4))
        0: put_chars("on");
        1: put_chars("Statu");
        2: put_chars("ONN");
        3: put_chars("PWM");
        default: begin
          put_chars("O");
          put_beat(8'h00, 1'b0, 1'b0);
          put_chars("N");
        end
      endcase
    end else if (r < 86) begin
      put_random($urandom_range(ucp_pkg::BUFFER_DEPTH + 4, ucp_pkg::BUFFER_DEPTH + 1));
    end else if (r < 89) begin
      put_random(ucp_pkg::BUFFER_DEPTH);
    end else if (r < 95) begin
      // receiver error at a random place in a good command
      put_good_command();
      pos = $urandom_range(cmd_q.size());
      cmd_q.insert(pos, '{8'($urandom_range(255)), 1'b0, 1'b1});
    end else begin
      put_good_command();
    end
    put_close(r >= 95);
  endfunction

  // Drive one beat and hold it until accepted
  task automatic send_beat(rx_beat_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b.ch;
    s_tlast  <= b.eoc;
    s_tuser  <= b.err;
    do @(posedge clk); while (!s_tready);
    sb.note_beat(b.ch, b.eoc, b.err);
  endtask

  task automatic send_command();
    foreach (cmd_q[i]) send_beat(cmd_q[i]);
    items += cmd_q.size();
    cmd_q.delete();
  endtask

  // Reply sink with random back-pressure
  initial begin : reply_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready   <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Stop the run when no beat moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_uart_led_pwm_command_parser: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    items   = 0;
    no_idle = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: enable, full duty, status, error on the closing beat, empty command
    put_chars("ON");
    put_close(1'b0);
    put_chars("PWM:100%");
    put_close(1'b0);
    put_chars("Status");
    put_close(1'b0);
    put_chars("OFF");
    put_close(1'b1);
    put_close(1'b0);
    send_command();

    // random commands, some stretches without any idling
    while (items < ITEM_TARGET) begin
      no_idle = ($urandom_range(3) == 0);
      build_command();
      send_command();
    end
    no_idle = 0;
    s_tvalid <= 1'b0;

    // drain the replies, then watch for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_uart_led_pwm_command_parser: PASS");
    end else begin
      $display("tb_uart_led_pwm_command_parser: FAIL");
    end
    $finish;
  end

endmodule
